### rtl/obbpo_pkg.sv
// Shared constants, types and helpers for the oriented-box overlap test.
package obbpo_pkg;

    localparam int FRAC_BITS = 16;

    localparam int ROW_W    = 2;
    localparam int ROT_W    = 18;
    localparam int OFF_W    = 32;
    localparam int HALF_W   = 31;
    localparam int DIMS     = 3;
    localparam int AXES     = 15;

    localparam int PROD_W   = OFF_W + ROT_W;
    localparam int SHIFT_W  = HALF_W + FRAC_BITS + 1;
    localparam int OFFSH_W  = OFF_W + FRAC_BITS + 1;
    localparam int BASE_W   = (SHIFT_W > PROD_W) ? SHIFT_W : PROD_W;
    localparam int WIDE_W   = (OFFSH_W > BASE_W) ? OFFSH_W : BASE_W;
    localparam int SUM_W    = WIDE_W + 3;

    typedef logic        [ROW_W-1:0]  row_t;
    typedef logic signed [ROT_W-1:0]  rot_t;
    typedef logic        [ROT_W-1:0]  mag_t;
    typedef logic signed [OFF_W-1:0]  off_t;
    typedef logic        [HALF_W-1:0] half_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic        [PROD_W-1:0] uprod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam row_t ROW_LAST = 2'd2;

    function automatic mag_t rot_mag(input rot_t v);
        mag_t r;
        r = v[ROT_W-1] ? mag_t'(-v) : mag_t'(v);
        return r;
    endfunction

    function automatic int nxt(input int i);
        int r;
        r = (i == DIMS - 1) ? 0 : i + 1;
        return r;
    endfunction

    function automatic int prv(input int i);
        int r;
        r = (i == 0) ? DIMS - 1 : i - 1;
        return r;
    endfunction

endpackage

### rtl/obb_pair_overlap_test.sv
// Top level: 15-axis separating axis overlap test for two oriented boxes.
// The result is valid once the row 2 transaction has passed every pipeline register.
// Throughput: one row transaction per cycle while m_ready does not stall the pipeline.
// The pipeline has four registers: snapshot, products, sums, compare.
// Reset clears the pipeline valid flags; stored rows stay undefined until written.
module obb_pair_overlap_test (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  obbpo_pkg::row_t   s_row_index,
    input  obbpo_pkg::rot_t   s_rot_x,
    input  obbpo_pkg::rot_t   s_rot_y,
    input  obbpo_pkg::rot_t   s_rot_z,
    input  obbpo_pkg::off_t   s_offset,
    input  obbpo_pkg::half_t  s_half_a,
    input  obbpo_pkg::half_t  s_half_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_collide
);
    import obbpo_pkg::*;

    rot_t   rot_store_reg    [ROW_LAST][DIMS];
    off_t   offset_store_reg [ROW_LAST];
    half_t  half_a_store_reg [ROW_LAST];
    half_t  half_b_store_reg [ROW_LAST];

    logic   v1_reg, v1_next;
    logic   v2_reg, v2_next;
    logic   v3_reg, v3_next;
    logic   m_valid_reg, m_valid_next;
    logic   collide_reg, collide_next;

    logic   en_out, en3, en2, en1, take_row, take_last;

    rot_t   rot1_reg  [DIMS][DIMS];
    mag_t   ab1_reg   [DIMS][DIMS];
    off_t   t1_reg    [DIMS];
    half_t  ha1_reg   [DIMS];
    half_t  hb1_reg   [DIMS];

    rot_t   in_rot    [DIMS];

    prod_t  pt2_reg   [DIMS][DIMS][DIMS];
    uprod_t pa2_reg   [DIMS][DIMS][DIMS];
    uprod_t pb2_reg   [DIMS][DIMS][DIMS];
    off_t   t2_reg    [DIMS];
    half_t  ha2_reg   [DIMS];
    half_t  hb2_reg   [DIMS];

    sum_t   lhs3_reg  [AXES];
    sum_t   rhs3_reg  [AXES];
    sum_t   lhs3_next [AXES];
    sum_t   rhs3_next [AXES];

    logic   [AXES-1:0] sep;

    assign en_out    = !m_valid_reg || m_ready;
    assign en3       = !v3_reg || en_out;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign s_ready   = en1;
    assign take_row  = s_valid && en1 && (s_row_index < ROW_LAST);
    assign take_last = s_valid && en1 && (s_row_index == ROW_LAST);

    assign in_rot[0] = s_rot_x;
    assign in_rot[1] = s_rot_y;
    assign in_rot[2] = s_rot_z;

    assign m_valid   = m_valid_reg;
    assign m_collide = collide_reg;

    always_comb begin
        v1_next      = en1    ? take_last : v1_reg;
        v2_next      = en2    ? v1_reg    : v2_reg;
        v3_next      = en3    ? v2_reg    : v3_reg;
        m_valid_next = en_out ? v3_reg    : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hold rows 0 and 1 until the closing row arrives
    always_ff @(posedge aclk) begin
        if (take_row) begin
            for (int c = 0; c < DIMS; c++) begin
                rot_store_reg[s_row_index[0]][c] <= in_rot[c];
            end
            offset_store_reg[s_row_index[0]] <= s_offset;
            half_a_store_reg[s_row_index[0]] <= s_half_a;
            half_b_store_reg[s_row_index[0]] <= s_half_b;
        end
    end

    // snapshot the whole query
    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int r = 0; r < DIMS - 1; r++) begin
                for (int c = 0; c < DIMS; c++) begin
                    rot1_reg[r][c] <= rot_store_reg[r][c];
                    ab1_reg[r][c]  <= rot_mag(rot_store_reg[r][c]);
                end
                t1_reg[r]  <= offset_store_reg[r];
                ha1_reg[r] <= half_a_store_reg[r];
                hb1_reg[r] <= half_b_store_reg[r];
            end
            for (int c = 0; c < DIMS; c++) begin
                rot1_reg[DIMS-1][c] <= in_rot[c];
                ab1_reg[DIMS-1][c]  <= rot_mag(in_rot[c]);
            end
            t1_reg[DIMS-1]  <= s_offset;
            ha1_reg[DIMS-1] <= s_half_a;
            hb1_reg[DIMS-1] <= s_half_b;
        end
    end

    // all products: index order is [scalar][row][column]
    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int i = 0; i < DIMS; i++) begin
                for (int r = 0; r < DIMS; r++) begin
                    for (int c = 0; c < DIMS; c++) begin
                        pt2_reg[i][r][c] <= prod_t'(t1_reg[i]) * prod_t'(rot1_reg[r][c]);
                        pa2_reg[i][r][c] <= uprod_t'(ha1_reg[i]) * uprod_t'(ab1_reg[r][c]);
                        pb2_reg[i][r][c] <= uprod_t'(hb1_reg[i]) * uprod_t'(ab1_reg[r][c]);
                    end
                end
                t2_reg[i]  <= t1_reg[i];
                ha2_reg[i] <= ha1_reg[i];
                hb2_reg[i] <= hb1_reg[i];
            end
        end
    end

    always_comb begin
        int c1, c2, r1, r2, k;
        for (int c = 0; c < DIMS; c++) begin
            lhs3_next[c] = sum_t'(t2_reg[c]) <<< FRAC_BITS;
            rhs3_next[c] = (sum_t'(ha2_reg[c]) << FRAC_BITS)
                         + sum_t'(pb2_reg[0][0][c])
                         + sum_t'(pb2_reg[1][1][c])
                         + sum_t'(pb2_reg[2][2][c]);
        end
        for (int r = 0; r < DIMS; r++) begin
            lhs3_next[DIMS + r] = sum_t'(pt2_reg[0][r][0])
                                + sum_t'(pt2_reg[1][r][1])
                                + sum_t'(pt2_reg[2][r][2]);
            rhs3_next[DIMS + r] = (sum_t'(hb2_reg[r]) << FRAC_BITS)
                                + sum_t'(pa2_reg[0][r][0])
                                + sum_t'(pa2_reg[1][r][1])
                                + sum_t'(pa2_reg[2][r][2]);
        end
        for (int c = 0; c < DIMS; c++) begin
            for (int r = 0; r < DIMS; r++) begin
                c1 = nxt(c);
                c2 = prv(c);
                r1 = nxt(r);
                r2 = prv(r);
                k  = 2 * DIMS + DIMS * c + r;
                lhs3_next[k] = sum_t'(pt2_reg[c2][r][c1]) - sum_t'(pt2_reg[c1][r][c2]);
                rhs3_next[k] = sum_t'(pa2_reg[c1][r][c2]) + sum_t'(pa2_reg[c2][r][c1])
                             + sum_t'(pb2_reg[r1][r2][c]) + sum_t'(pb2_reg[r2][r1][c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int k = 0; k < AXES; k++) begin
                lhs3_reg[k] <= lhs3_next[k];
                rhs3_reg[k] <= rhs3_next[k];
            end
        end
    end

    always_comb begin
        sum_t m;
        for (int k = 0; k < AXES; k++) begin
            m      = lhs3_reg[k][SUM_W-1] ? -lhs3_reg[k] : lhs3_reg[k];
            sep[k] = m > rhs3_reg[k];
        end
        collide_next = ~(|sep);
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            collide_reg <= collide_next;
        end
    end

    a_last_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_row_index == ROW_LAST) |=> v1_reg)
        else $error("closing row did not enter the pipeline");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg && !(s_valid && s_ready && (s_row_index == ROW_LAST)) |=> !v1_reg)
        else $error("pipeline filled without a closing row");

    a_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && (!m_valid || m_ready) |=> m_valid)
        else $error("finished query did not reach the result register");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && v3_reg |=> v3_reg)
        else $error("last stage dropped a query while stalled");

endmodule

### test/obb_pair_overlap_test_chk.sv
// Checker for the oriented-box overlap test: mirrors the row stores and checks each collide flag.
module obb_pair_overlap_test_chk (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  obbpo_pkg::row_t   s_row_index,
    input  obbpo_pkg::rot_t   s_rot_x,
    input  obbpo_pkg::rot_t   s_rot_y,
    input  obbpo_pkg::rot_t   s_rot_z,
    input  obbpo_pkg::off_t   s_offset,
    input  obbpo_pkg::half_t  s_half_a,
    input  obbpo_pkg::half_t  s_half_b,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_collide,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import obbpo_pkg::*;

    rot_t  rot_rows [DIMS][DIMS];
    off_t  off_rows [DIMS];
    half_t ha_rows  [DIMS];
    half_t hb_rows  [DIMS];
    bit    collide_q[$];

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit boxes_collide();
        longint one, lhs, rhs;
        longint t [DIMS];
        longint ha[DIMS];
        longint hb[DIMS];
        longint rs[DIMS][DIMS];
        longint ra[DIMS][DIMS];
        int     c1, c2, r1, r2;
        bit     hit;
        one = longint'(1) << FRAC_BITS;
        hit = 1'b1;
        for (int i = 0; i < DIMS; i++) begin
            t[i]  = longint'(off_rows[i]);
            ha[i] = longint'(ha_rows[i]);
            hb[i] = longint'(hb_rows[i]);
            for (int j = 0; j < DIMS; j++) begin
                rs[i][j] = longint'(rot_rows[i][j]);
                ra[i][j] = mag64(rs[i][j]);
            end
        end
        for (int c = 0; c < DIMS; c++) begin
            lhs = mag64(t[c]) * one;
            rhs = ha[c] * one + hb[0] * ra[0][c] + hb[1] * ra[1][c] + hb[2] * ra[2][c];
            if (lhs > rhs) hit = 1'b0;
        end
        for (int r = 0; r < DIMS; r++) begin
            lhs = mag64(t[0] * rs[r][0] + t[1] * rs[r][1] + t[2] * rs[r][2]);
            rhs = hb[r] * one + ha[0] * ra[r][0] + ha[1] * ra[r][1] + ha[2] * ra[r][2];
            if (lhs > rhs) hit = 1'b0;
        end
        for (int c = 0; c < DIMS; c++) begin
            c1 = (c + 1) % DIMS;
            c2 = (c + 2) % DIMS;
            for (int r = 0; r < DIMS; r++) begin
                r1  = (r + 1) % DIMS;
                r2  = (r + 2) % DIMS;
                lhs = mag64(t[c2] * rs[r][c1] - t[c1] * rs[r][c2]);
                rhs = ha[c1] * ra[r][c2] + ha[c2] * ra[r][c1]
                    + hb[r1] * ra[r2][c] + hb[r2] * ra[r1][c];
                if (lhs > rhs) hit = 1'b0;
            end
        end
        return hit;
    endfunction

    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            collide_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (collide_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: collide expected none, actual %0b", $time, m_collide);
                end else begin
                    want = collide_q.pop_front();
                    if (m_collide !== want) begin
                        fail_count++;
                        $display("%0t: collide expected %0b, actual %0b",
                                 $time, want, m_collide);
                    end
                end
            end
            if (s_valid && s_ready && s_row_index <= ROW_LAST) begin
                rot_rows[s_row_index][0] = s_rot_x;
                rot_rows[s_row_index][1] = s_rot_y;
                rot_rows[s_row_index][2] = s_rot_z;
                off_rows[s_row_index]    = s_offset;
                ha_rows[s_row_index]     = s_half_a;
                hb_rows[s_row_index]     = s_half_b;
                if (s_row_index == ROW_LAST)
                    collide_q.insert(collide_q.size(), boxes_collide());
            end
        end
        pending = collide_q.size();
    end

endmodule

### test/obb_pair_overlap_test_tb.sv
// Testbench top for the oriented-box overlap test: clock, reset, row stimulus and verdict.
module obb_pair_overlap_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import obbpo_pkg::*;

    localparam int   ONE         = 1 << FRAC_BITS;
    localparam row_t ROW_SPARE   = 2'd3;
    localparam int   HOLD_CYCLES = 300;
    localparam int   STALL_LIMIT = 4000;
    localparam int   ITEMS       = 1150;

    typedef struct {
        row_t  row;
        rot_t  rx;
        rot_t  ry;
        rot_t  rz;
        off_t  off;
        half_t ha;
        half_t hb;
    } row_item_t;

    logic  aclk        = 1'b0;
    logic  aresetn     = 1'b0;
    logic  s_valid     = 1'b0;
    logic  s_ready;
    row_t  s_row_index = '0;
    rot_t  s_rot_x     = '0;
    rot_t  s_rot_y     = '0;
    rot_t  s_rot_z     = '0;
    off_t  s_offset    = '0;
    half_t s_half_a    = '0;
    half_t s_half_b    = '0;
    logic  m_valid;
    logic  m_ready     = 1'b0;
    logic  m_collide;

    int fail_count;
    int pending;
    int send_idle  = 0;
    int recv_idle  = 0;
    bit hold_start = 1'b0;
    int hold_left  = 0;
    int n_items    = 0;
    int idle_run   = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    obb_pair_overlap_test i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_index (s_row_index),
        .s_rot_x     (s_rot_x),
        .s_rot_y     (s_rot_y),
        .s_rot_z     (s_rot_z),
        .s_offset    (s_offset),
        .s_half_a    (s_half_a),
        .s_half_b    (s_half_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_collide   (m_collide)
    );

    obb_pair_overlap_test_chk i_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_index (s_row_index),
        .s_rot_x     (s_rot_x),
        .s_rot_y     (s_rot_y),
        .s_rot_z     (s_rot_z),
        .s_offset    (s_offset),
        .s_half_a    (s_half_a),
        .s_half_b    (s_half_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_collide   (m_collide),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // hold off the result channel for a long stretch when asked
    always @(negedge aclk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run = 0;
        end else if (++idle_run >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic row_item_t mk_row(input row_t r, input int rx, input int ry,
                                         input int rz, input int off, input int ha,
                                         input int hb);
        row_item_t it;
        it.row = r;
        it.rx  = rot_t'(rx);
        it.ry  = rot_t'(ry);
        it.rz  = rot_t'(rz);
        it.off = off_t'(off);
        it.ha  = half_t'(ha);
        it.hb  = half_t'(hb);
        return it;
    endfunction

    // style 0: unit-range rotation, 1: raw bits everywhere, 2: axis-aligned rotation
    function automatic int rand_rot(input int style);
        int v;
        case (style)
            0:       v = int'($urandom_range(2 * ONE)) - ONE;
            1:       v = int'($urandom);
            default: v = (int'($urandom_range(2)) - 1) * ONE;
        endcase
        return v;
    endfunction

    function automatic row_item_t rand_row(input row_t r, input int style, input int scale);
        int off, ha, hb;
        if (style == 1) begin
            off = int'($urandom);
            ha  = int'($urandom);
            hb  = int'($urandom);
        end else begin
            ha  = int'($urandom_range(1 << scale));
            hb  = int'($urandom_range(1 << scale));
            off = int'($urandom_range(4 << scale)) - (2 << scale);
        end
        return mk_row(r, rand_rot(style), rand_rot(style), rand_rot(style), off, ha, hb);
    endfunction

    task automatic drive_row(input row_item_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_index <= it.row;
        s_rot_x     <= it.rx;
        s_rot_y     <= it.ry;
        s_rot_z     <= it.rz;
        s_offset    <= it.off;
        s_half_a    <= it.ha;
        s_half_b    <= it.hb;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
        if (it.row != ROW_SPARE) n_items++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    initial begin
        int kind, style, scale, first;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // boxes at the same centre
        for (int r = 0; r <= ROW_LAST; r++)
            drive_row(mk_row(row_t'(r), (r == 0) ? ONE : 0, (r == 1) ? ONE : 0,
                             (r == 2) ? ONE : 0, 0, ONE, ONE));
        // touching on A axis 0, then one step apart
        drive_row(mk_row(row_t'(0), ONE, 0, 0, 2 * ONE, ONE, ONE));
        drive_row(mk_row(ROW_LAST, 0, 0, ONE, 0, ONE, ONE));
        drive_row(mk_row(row_t'(0), ONE, 0, 0, 2 * ONE + 1, ONE, ONE));
        drive_row(mk_row(ROW_LAST, 0, 0, ONE, 0, ONE, ONE));
        // spare row index must leave the stores alone
        drive_row(mk_row(ROW_SPARE, -ONE, -ONE, -ONE, 0, 0, 0));
        drive_row(mk_row(ROW_LAST, 0, 0, ONE, 0, ONE, ONE));
        // field extremes
        for (int r = 0; r <= ROW_LAST; r++)
            drive_row(mk_row(row_t'(r), 131071, 131071, 131071, int'(32'h7fffffff),
                             int'(32'h7fffffff), int'(32'h7fffffff)));
        for (int r = 0; r <= ROW_LAST; r++)
            drive_row(mk_row(row_t'(r), -131072, -131072, -131072, int'(32'h80000000), 0, 0));
        // quarter turn about A axis 2
        drive_row(mk_row(row_t'(0), 0, ONE, 0, 3 * ONE, 2 * ONE, ONE));
        drive_row(mk_row(row_t'(1), -ONE, 0, 0, ONE, ONE, 2 * ONE));
        drive_row(mk_row(ROW_LAST, 0, 0, ONE, -ONE, ONE, ONE));
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 36; recv_idle = 60; end
                1: begin send_idle = 60; recv_idle = 36; end
                default: begin
                    send_idle  = 0;
                    recv_idle  = 0;
                    hold_start = 1'b1;
                end
            endcase
            while (n_items < 18 + (ph + 1) * (ITEMS - 18) / 3) begin
                kind  = $urandom_range(99);
                style = ($urandom_range(9) < 6) ? 0 : ($urandom_range(1) ? 1 : 2);
                scale = $urandom_range(28, 4);
                first = $urandom_range(1);
                if (kind < 70) begin
                    drive_row(rand_row(row_t'(first), style, scale));
                    drive_row(rand_row(row_t'(1 - first), style, scale));
                    drive_row(rand_row(ROW_LAST, style, scale));
                end else if (kind < 82) begin
                    drive_row(rand_row(row_t'(first), style, scale));
                    drive_row(rand_row(ROW_LAST, style, scale));
                end else if (kind < 88) begin
                    drive_row(rand_row(ROW_LAST, style, scale));
                end else if (kind < 94) begin
                    drive_row(rand_row(ROW_SPARE, 1, scale));
                end else begin
                    drive_row(rand_row(row_t'(first), style, scale));
                end
            end
            wait_drained();
        end

        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
